// File: src/cbp_pkg.sv
// Shared constants and types for the capsule versus box penetration pipeline.
// No dependencies; used by the top level and its square root and divide pipes.
package cbp_pkg;

  localparam int unsigned SQRT_STAGES = 31;
  localparam int unsigned DIV_STAGES  = 17;
  localparam int unsigned VAL_W       = 31;
  localparam int unsigned SQ_W        = 62;
  localparam int unsigned NUM_W       = VAL_W + 16;
  localparam int unsigned QUO_W       = DIV_STAGES;
  localparam int unsigned NRM_W       = 18;
  localparam logic [QUO_W-1:0] ONE_Q16 = QUO_W'(65536);

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOX    = 2'd1,
    ST_RADIUS = 2'd2
  } status_e;

endpackage

// File: src/cbp_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on cbp_pkg for the stage count and widths.
module cbp_isqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [cbp_pkg::SQ_W-1:0]   s_i,
  output logic [cbp_pkg::VAL_W-1:0]  res_o
);
  import cbp_pkg::*;

  logic [63:0] rem_in [SQRT_STAGES];
  logic [63:0] res_in [SQRT_STAGES];
  logic [63:0] rem_d  [SQRT_STAGES];
  logic [63:0] res_d  [SQRT_STAGES];
  logic [63:0] rem_q  [SQRT_STAGES];
  logic [63:0] res_q  [SQRT_STAGES];

  assign rem_in[0] = 64'(s_i);
  assign res_in[0] = 64'd0;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
    localparam logic [63:0] StepBit = 64'd1 << (2 * (SQRT_STAGES - 1 - k));
    logic [63:0] trial;
    if (k > 0) begin : g_link
      assign rem_in[k] = rem_q[k-1];
      assign res_in[k] = res_q[k-1];
    end
    assign trial = res_in[k] + StepBit;
    always_comb begin
      if (rem_in[k] >= trial) begin
        rem_d[k] = rem_in[k] - trial;
        res_d[k] = (res_in[k] >> 1) + StepBit;
      end else begin
        rem_d[k] = rem_in[k];
        res_d[k] = res_in[k] >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d[k];
        res_q[k] <= res_d[k];
      end
    end
  end

  assign res_o = res_q[SQRT_STAGES-1][VAL_W-1:0];

endmodule

// File: src/cbp_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on cbp_pkg for the stage count and widths.
module cbp_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [cbp_pkg::NUM_W-1:0]  num_i,
  input  logic [cbp_pkg::VAL_W-1:0]  den_i,
  output logic [cbp_pkg::QUO_W-1:0]  q_o
);
  import cbp_pkg::*;

  logic [NUM_W-1:0] rem_in [DIV_STAGES];
  logic [VAL_W-1:0] den_in [DIV_STAGES];
  logic [QUO_W-1:0] quo_in [DIV_STAGES];
  logic [NUM_W-1:0] rem_q  [DIV_STAGES];
  logic [VAL_W-1:0] den_q  [DIV_STAGES];
  logic [QUO_W-1:0] quo_q  [DIV_STAGES];

  assign rem_in[0] = num_i;
  assign den_in[0] = den_i;
  assign quo_in[0] = '0;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    localparam int unsigned Sh = DIV_STAGES - 1 - k;
    logic [NUM_W:0] bound;
    logic           take;
    if (k > 0) begin : g_link
      assign rem_in[k] = rem_q[k-1];
      assign den_in[k] = den_q[k-1];
      assign quo_in[k] = quo_q[k-1];
    end
    assign bound = (NUM_W+1)'(den_in[k]) << Sh;
    assign take  = ({1'b0, rem_in[k]} >= bound);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? NUM_W'({1'b0, rem_in[k]} - bound) : rem_in[k];
        den_q[k] <= den_in[k];
        quo_q[k] <= take ? (quo_in[k] | (QUO_W'(1) << Sh)) : quo_in[k];
      end
    end
  end

  assign q_o = quo_q[DIV_STAGES-1];

endmodule

// File: src/capsule_box_penetration_top.sv
// Capsule versus axis-aligned box penetration, fully pipelined top level.
// Depends on cbp_pkg, cbp_isqrt and cbp_div.
//
// One item per clock is accepted unless the output holds, and each item
// yields one result after four stages of clamping, squaring and summing, 31
// square root stages, 17 divide stages for the normal and the output register.
// All stages advance together and hold while a result waits on the output.
module capsule_box_penetration_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cap_x, cap_y, cap_z, cap_half_height, cap_radius, box_lo_x, box_lo_y,
  // box_lo_z, box_hi_x, box_hi_y, box_hi_z, zero fill
  input  logic [351:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, hit, depth, normal_x, normal_y, normal_z
  output logic [87:0]  m_axis_tdata
);
  import cbp_pkg::*;

  typedef struct packed {
    status_e          status;
    logic             hit;
    logic [VAL_W-1:0] r;
    logic             nx_s, ny_s, nz_s;
    logic [VAL_W-1:0] ax, ay, az;
  } sa_t;

  typedef struct packed {
    status_e          status;
    logic             hit;
    logic [VAL_W-1:0] r;
    logic             nx_s, ny_s, nz_s;
    logic [VAL_W-1:0] d;
  } sb_t;

  logic en;
  logic signed [31:0] cx, cy, cz, lx, ly, lz, hx, hy, hz;
  logic [VAL_W-1:0]   hh, rad;

  assign cx  = s_axis_tdata[31:0];
  assign cy  = s_axis_tdata[63:32];
  assign cz  = s_axis_tdata[95:64];
  assign hh  = s_axis_tdata[126:96];
  assign rad = s_axis_tdata[157:127];
  assign lx  = s_axis_tdata[189:158];
  assign ly  = s_axis_tdata[221:190];
  assign lz  = s_axis_tdata[253:222];
  assign hx  = s_axis_tdata[285:254];
  assign hy  = s_axis_tdata[317:286];
  assign hz  = s_axis_tdata[349:318];

  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: checks, x/z separation, y segment ends
  status_e            st1_d, st1_q;
  logic signed [32:0] vx1_d, vz1_d, vx1_q, vz1_q;
  logic signed [33:0] c2_d, ya_d, yb_d, c2_q, ya_q, yb_q;
  logic signed [31:0] ly1_q, hy1_q;
  logic [VAL_W-1:0]   r1_q;

  always_comb begin
    if (lx >= hx || ly >= hy || lz >= hz) begin
      st1_d = ST_BOX;
    end else if (rad == '0) begin
      st1_d = ST_RADIUS;
    end else begin
      st1_d = ST_OK;
    end
    if (cx < lx) vx1_d = 33'(cx) - 33'(lx);
    else if (cx > hx) vx1_d = 33'(cx) - 33'(hx);
    else vx1_d = '0;
    if (cz < lz) vz1_d = 33'(cz) - 33'(lz);
    else if (cz > hz) vz1_d = 33'(cz) - 33'(hz);
    else vz1_d = '0;
    c2_d = 34'(ly) + 34'(hy);
    ya_d = 34'(cy) - $signed({3'b000, hh});
    yb_d = 34'(cy) + $signed({3'b000, hh});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st1_q <= st1_d;
      vx1_q <= vx1_d;
      vz1_q <= vz1_d;
      c2_q  <= c2_d;
      ya_q  <= ya_d;
      yb_q  <= yb_d;
      ly1_q <= ly;
      hy1_q <= hy;
      r1_q  <= rad;
    end
  end

  // stage 2: y separation, magnitudes, far test
  logic signed [34:0] ysel, vy2;
  logic               lt2, gt2;
  logic [32:0]        ax2;
  logic [34:0]        ay2;
  logic [32:0]        az2;
  logic               near2;
  status_e            st2_q;
  logic               ok2_q;
  logic               sx2_q, sy2_q, sz2_q;
  logic [VAL_W-1:0]   ax2_q, ay2_q, az2_q, r2_q;

  always_comb begin
    lt2  = ($signed({c2_q[33], c2_q}) < $signed({ya_q, 1'b0}));
    gt2  = ($signed({c2_q[33], c2_q}) > $signed({yb_q, 1'b0}));
    ysel = lt2 ? 35'(ya_q) : 35'(yb_q);
    if (!(lt2 || gt2)) vy2 = '0;
    else if (ysel < 35'(ly1_q)) vy2 = ysel - 35'(ly1_q);
    else if (ysel > 35'(hy1_q)) vy2 = ysel - 35'(hy1_q);
    else vy2 = '0;
    ax2   = vx1_q[32] ? 33'(-vx1_q) : 33'(vx1_q);
    ay2   = vy2[34] ? 35'(-vy2) : 35'(vy2);
    az2   = vz1_q[32] ? 33'(-vz1_q) : 33'(vz1_q);
    near2 = (ax2 < 33'(r1_q)) && (ay2 < 35'(r1_q)) && (az2 < 33'(r1_q));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st2_q <= st1_q;
      ok2_q <= (st1_q == ST_OK) && near2;
      sx2_q <= vx1_q[32];
      sy2_q <= vy2[34];
      sz2_q <= vz1_q[32];
      ax2_q <= near2 ? ax2[VAL_W-1:0] : '0;
      ay2_q <= near2 ? ay2[VAL_W-1:0] : '0;
      az2_q <= near2 ? az2[VAL_W-1:0] : '0;
      r2_q  <= r1_q;
    end
  end

  // stage 3: squares
  logic [SQ_W-1:0] qx3_q, qy3_q, qz3_q, rr3_q;
  sa_t             a3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx3_q <= SQ_W'(ax2_q) * SQ_W'(ax2_q);
      qy3_q <= SQ_W'(ay2_q) * SQ_W'(ay2_q);
      qz3_q <= SQ_W'(az2_q) * SQ_W'(az2_q);
      rr3_q <= SQ_W'(r2_q) * SQ_W'(r2_q);
      a3_q  <= '{status: st2_q, hit: ok2_q, r: r2_q, nx_s: sx2_q,
                 ny_s: sy2_q, nz_s: sz2_q, ax: ax2_q, ay: ay2_q, az: az2_q};
    end
  end

  // stage 4: sum and hit test
  logic [SQ_W+1:0] sum4;
  logic            hit4;
  logic [SQ_W-1:0] s4_q;
  sa_t             a4_d, a4_q;

  assign sum4 = (SQ_W+2)'(qx3_q) + (SQ_W+2)'(qy3_q) + (SQ_W+2)'(qz3_q);
  assign hit4 = a3_q.hit && (sum4 < (SQ_W+2)'(rr3_q));

  always_comb begin
    a4_d     = a3_q;
    a4_d.hit = hit4;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q <= hit4 ? sum4[SQ_W-1:0] : '0;
      a4_q <= a4_d;
    end
  end

  // square root with side data alongside
  logic [VAL_W-1:0] root;
  sa_t              sa_q [SQRT_STAGES];

  cbp_isqrt u_isqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .s_i   (s4_q),
    .res_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q[0] <= a4_q;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        sa_q[i] <= sa_q[i-1];
      end
    end
  end

  // normal division with side data alongside
  sa_t              sa_end;
  logic [QUO_W-1:0] qx, qy, qz;
  sb_t              sb_q [DIV_STAGES];

  assign sa_end = sa_q[SQRT_STAGES-1];

  cbp_div u_div_x (
    .clk_i (clk_i), .en_i (en), .num_i ({sa_end.ax, 16'h0000}),
    .den_i (root), .q_o (qx)
  );
  cbp_div u_div_y (
    .clk_i (clk_i), .en_i (en), .num_i ({sa_end.ay, 16'h0000}),
    .den_i (root), .q_o (qy)
  );
  cbp_div u_div_z (
    .clk_i (clk_i), .en_i (en), .num_i ({sa_end.az, 16'h0000}),
    .den_i (root), .q_o (qz)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= '{status: sa_end.status, hit: sa_end.hit,
                   r: sa_end.r, nx_s: sa_end.nx_s, ny_s: sa_end.ny_s,
                   nz_s: sa_end.nz_s, d: root};
      for (int i = 1; i < DIV_STAGES; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  // valid line for every stage
  localparam int unsigned VLD_N = 4 + SQRT_STAGES + DIV_STAGES;
  logic [VLD_N-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[VLD_N-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[VLD_N-1];
    end
  end

  // output stage
  sb_t                     sb_end;
  logic [QUO_W-1:0]        mx, my, mz;
  logic signed [NRM_W-1:0] nx_d, ny_d, nz_d;
  logic [VAL_W-1:0]        depth_d;
  logic [87:0]             out_q;

  assign sb_end = sb_q[DIV_STAGES-1];
  assign mx = (qx > ONE_Q16) ? ONE_Q16 : qx;
  assign my = (qy > ONE_Q16) ? ONE_Q16 : qy;
  assign mz = (qz > ONE_Q16) ? ONE_Q16 : qz;

  always_comb begin
    nx_d    = '0;
    ny_d    = '0;
    nz_d    = '0;
    depth_d = '0;
    if (sb_end.hit) begin
      depth_d = sb_end.r - sb_end.d;
      if (sb_end.d == '0) begin
        ny_d = NRM_W'(ONE_Q16);
      end else begin
        nx_d = sb_end.nx_s ? -NRM_W'(mx) : NRM_W'(mx);
        ny_d = sb_end.ny_s ? -NRM_W'(my) : NRM_W'(my);
        nz_d = sb_end.nz_s ? -NRM_W'(mz) : NRM_W'(mz);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {nz_d, ny_d, nx_d, depth_d, sb_end.hit, sb_end.status};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
